FILE: src/ffba_pkg.sv
// shared types and constants for the first-fit block allocator
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  // defaults and fixed geometry
  localparam int MAX_BLOCKS_DEF = 64;
  localparam int WORD_BYTES     = 8;   // allocation granule, a power of two
  localparam int HEADER_BYTES   = 24;

  localparam int REQ_W  = 16;
  localparam int IDX_W  = 6;
  localparam int SIZE_W = 17;
  localparam int ADDR_W = 21;
  localparam int STAT_W = 3;

  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = ADDR_W'(1048576);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } ffba_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_REUSED = 3'd0,
    ST_NEW    = 3'd1,
    ST_NO_MEM = 3'd2,
    ST_FULL   = 3'd3,
    ST_FREE   = 3'd4
  } ffba_status_t;

  typedef struct packed {
    ffba_cmd_t          command;
    logic [REQ_W-1:0]   request_size;
    logic [IDX_W-1:0]   block_index;
  } ffba_req_t;

  typedef struct packed {
    ffba_status_t       status;
    logic [IDX_W-1:0]   result_index;
    logic [ADDR_W-1:0]  payload_address;
    logic [SIZE_W-1:0]  granted_size;
  } ffba_res_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               capture;     // latch the fit compare for a new word
    logic               resolve;     // apply this word's table update
    logic               free_op;     // word being resolved is a free
    logic               append;      // append a new entry at the slot given
    logic [SIZE_W-1:0]  alloc_size;  // rounded size (valid with capture and resolve)
    logic [IDX_W-1:0]   free_index;
    logic [ADDR_W-1:0]  append_base;
  } ffba_cell_ctl_t;

  // one cell's contribution to the result, zero unless picked
  typedef struct packed {
    logic               pick;
    logic [SIZE_W-1:0]  size;
    logic [ADDR_W-1:0]  base;
  } ffba_cell_out_t;

endpackage

`default_nettype wire

FILE: src/ffba_cell.sv
// one table entry of the allocator with its link in the first-fit chain
`timescale 1ns / 1ps
`default_nettype none

module ffba_cell #(
  parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int CELL_ID    = 0,
  localparam int CNT_W     = $clog2(MAX_BLOCKS + 1)
) (
  input  wire                     clk,
  input  wire                     rst,
  input  ffba_pkg::ffba_cell_ctl_t ctl,
  input  wire  [CNT_W-1:0]        block_count,
  input  wire                     prior_in,
  output logic                    prior_out,
  output ffba_pkg::ffba_cell_out_t cell_out
);

  logic [ffba_pkg::SIZE_W-1:0] size;
  logic [ffba_pkg::ADDR_W-1:0] base;
  logic                        used;
  logic                        valid;
  logic                        hit;

  logic grant;
  logic free_sel;
  logic append_sel;

  // an earlier fitting entry blocks this one
  assign grant      = hit & ~ctl.free_op & ~prior_in;
  assign prior_out  = prior_in | (hit & ~ctl.free_op);
  assign free_sel   = ctl.free_op & valid &
                      (32'(ctl.free_index) == CELL_ID);
  assign append_sel = ctl.append & (block_count == CNT_W'(CELL_ID));

  always_comb begin
    cell_out.pick = grant | free_sel;
    cell_out.size = (grant | free_sel) ? size : '0;
    cell_out.base = (grant | free_sel) ? base : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= 1'b0;
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (ctl.capture) begin
        hit <= valid & ~used & (size >= ctl.alloc_size);
      end
      if (ctl.resolve) begin
        if (grant) begin
          used <= 1'b1;
        end else if (free_sel) begin
          used <= 1'b0;
        end else if (append_sel) begin
          used  <= 1'b1;
          valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.resolve && append_sel) begin
      size <= ctl.alloc_size;
      base <= ctl.append_base;
    end
  end

endmodule

`default_nettype wire

FILE: src/first_fit_block_allocator_core.sv
// top level of the first-fit block allocator: controller and row of entry cells
`timescale 1ns / 1ps
`default_nettype none

// channel       ports                              handshake
// ------------  ---------------------------------  ---------------------------------
// request       req (command, size, index)         taken when start high, busy low
// result        result (status, index, addr, size)  shown for one cycle with done high
// heap limit    heap_limit_we, heap_limit_wdata    written when heap_limit_we high
//
// for each request word the accept edge latches the fit compare in every cell,
// then in the resolve state the first-fit chain is resolved and the table updated
// done pulses in the cycle after the resolve state, while a new word can already be taken
// rst (synchronous) empties the table, zeroes the heap break, sets the limit to 1 MiB
// results cannot be stalled; busy is high only during the resolve cycle

module first_fit_block_allocator_core #(
  parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  ffba_pkg::ffba_req_t          req,
  input  wire                          heap_limit_we,
  input  wire  [ffba_pkg::ADDR_W-1:0]  heap_limit_wdata,
  output logic                         done,
  output ffba_pkg::ffba_res_t          result
);

  localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
  localparam int SLOT_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int NEED_W   = ffba_pkg::ADDR_W + 1;
  localparam logic [ffba_pkg::SIZE_W-1:0] GRAIN_MASK =
    ffba_pkg::SIZE_W'(ffba_pkg::WORD_BYTES - 1);

  typedef enum logic [1:0] {
    S_IDLE    = 2'b01,
    S_RESOLVE = 2'b10
  } state_t;

  state_t state, state_next;

  // latched request word
  ffba_pkg::ffba_cmd_t           cmd;
  logic [ffba_pkg::SIZE_W-1:0]   alloc_size;
  logic [ffba_pkg::IDX_W-1:0]    free_index;

  // allocator state
  logic [CNT_W-1:0]              block_count;
  logic [ffba_pkg::ADDR_W-1:0]   heap_break;
  logic [ffba_pkg::ADDR_W-1:0]   heap_limit;

  logic                          accept;
  logic [ffba_pkg::SIZE_W-1:0]   round_size;
  logic                          resolve;
  logic                          found;
  logic                          table_full;
  logic                          no_mem;
  logic                          append;
  logic [NEED_W-1:0]             need;

  ffba_pkg::ffba_cell_ctl_t      ctl;
  ffba_pkg::ffba_cell_out_t      cell_out [MAX_BLOCKS];
  logic [MAX_BLOCKS:0]           prior;

  logic                          any_pick;
  logic [SLOT_W-1:0]             pick_slot;
  logic [ffba_pkg::SIZE_W-1:0]   pick_size;
  logic [ffba_pkg::ADDR_W-1:0]   pick_base;

  ffba_pkg::ffba_res_t           result_next;

  assign busy    = (state == S_RESOLVE);
  assign accept  = start & ~busy;
  assign resolve = (state == S_RESOLVE);

  // round up to the allocation granule
  assign round_size = (ffba_pkg::SIZE_W'(req.request_size) + GRAIN_MASK) & ~GRAIN_MASK;

  // new block would end here, one spare bit so the compare never wraps
  assign need = NEED_W'(heap_break) + NEED_W'(alloc_size) +
                NEED_W'(ffba_pkg::HEADER_BYTES);

  assign found      = prior[MAX_BLOCKS];
  assign table_full = (block_count == CNT_W'(MAX_BLOCKS));
  assign no_mem     = (need > NEED_W'(heap_limit));
  assign append     = resolve & (cmd == ffba_pkg::CMD_ALLOC) & ~found &
                      ~table_full & ~no_mem;

  // compare size taken straight from the port on accept, from the latch afterwards
  always_comb begin
    ctl.capture     = accept;
    ctl.resolve     = resolve;
    ctl.free_op     = (cmd == ffba_pkg::CMD_FREE);
    ctl.append      = append;
    ctl.alloc_size  = accept ? round_size : alloc_size;
    ctl.free_index  = free_index;
    ctl.append_base = heap_break;
  end

  // row of cells, the chain carries "an earlier entry already fits"
  assign prior[0] = 1'b0;

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    ffba_cell #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .CELL_ID    (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .block_count (block_count),
      .prior_in    (prior[i]),
      .prior_out   (prior[i+1]),
      .cell_out    (cell_out[i])
    );
  end

  // at most one cell is picked, so an or over the row reads it out
  always_comb begin
    any_pick  = 1'b0;
    pick_slot = '0;
    pick_size = '0;
    pick_base = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      any_pick  = any_pick | cell_out[i].pick;
      pick_size = pick_size | cell_out[i].size;
      pick_base = pick_base | cell_out[i].base;
      if (cell_out[i].pick) begin
        pick_slot = pick_slot | SLOT_W'(i);
      end
    end
  end

  // result for the word being resolved
  always_comb begin
    result_next = '0;
    if (cmd == ffba_pkg::CMD_FREE) begin
      result_next.status       = ffba_pkg::ST_FREE;
      result_next.result_index = free_index;
      if (any_pick) begin
        result_next.payload_address =
          pick_base + ffba_pkg::ADDR_W'(ffba_pkg::HEADER_BYTES);
        result_next.granted_size = pick_size;
      end
    end else if (found) begin
      result_next.status          = ffba_pkg::ST_REUSED;
      result_next.result_index    = ffba_pkg::IDX_W'(pick_slot);
      result_next.payload_address =
        pick_base + ffba_pkg::ADDR_W'(ffba_pkg::HEADER_BYTES);
      result_next.granted_size    = pick_size;
    end else if (table_full) begin
      result_next.status = ffba_pkg::ST_FULL;
    end else if (no_mem) begin
      result_next.status = ffba_pkg::ST_NO_MEM;
    end else begin
      result_next.status          = ffba_pkg::ST_NEW;
      result_next.result_index    = ffba_pkg::IDX_W'(block_count);
      result_next.payload_address =
        heap_break + ffba_pkg::ADDR_W'(ffba_pkg::HEADER_BYTES);
      result_next.granted_size    = alloc_size;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      block_count <= '0;
      heap_break  <= '0;
      heap_limit  <= ffba_pkg::HEAP_LIMIT_RST;
    end else begin
      state <= state_next;
      done  <= resolve;
      if (heap_limit_we) begin
        heap_limit <= heap_limit_wdata;
      end
      if (append) begin
        block_count <= block_count + CNT_W'(1);
        heap_break  <= need[ffba_pkg::ADDR_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd        <= req.command;
      alloc_size <= round_size;
      free_index <= req.block_index;
    end
    if (resolve) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire
